@@ src/cmvg_pkg.sv @@
// Shared types, constants and helper functions for the cylinder mesh vertex generator.
// No dependencies; every other file of the block imports this package.
package cmvg_pkg;

    // Field and register widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int RS_W       = 9;
    localparam int WC_W       = 11;
    localparam int K_W        = 10;
    localparam int MODE_W     = 2;
    localparam int BAND_W     = 8;
    localparam int POS_W      = 15;
    localparam int NRM_W      = 16;

    // Geometry limits
    localparam int MAX_WEDGES = 1024;
    localparam int MIN_WEDGES = 3;
    localparam int MAX_BANDS  = 256;
    localparam int FRAC_BITS  = 14;

    localparam logic [RS_W-1:0] RS_RESET = RS_W'(1);
    localparam logic [WC_W-1:0] WC_RESET = WC_W'(3);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_STEPS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEDGE_COUNT  = CFG_IDX_W'(1);

    // Surface codes
    localparam logic [MODE_W-1:0] MODE_TOP    = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_BOTTOM = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_SIDE   = MODE_W'(2);

    localparam int VERTS  = 6;
    localparam int VIDX_W = 3;

    // Rotation unit
    localparam int CORDIC_STEPS = 20;
    localparam int IT_W         = 5;
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam int TRIG_W       = 32;
    localparam int ATAN_W       = 30;
    localparam logic signed [XY_W-1:0]   CORDIC_X0 = XY_W'(652032874);
    localparam logic signed [TRIG_W-1:0] Q30_ONE   = TRIG_W'(1073741824);

    // Scaling from Q1.30 to the output format
    localparam int POS_SHIFT = 31 - FRAC_BITS;
    localparam int NRM_SHIFT = 30 - FRAC_BITS;
    localparam logic [POS_W-1:0] CAP_Y   = POS_W'(1 << (FRAC_BITS - 1));
    localparam logic [NRM_W-1:0] NRM_ONE = NRM_W'(1 << FRAC_BITS);

    // Shared divider
    localparam int DIV_NUM_W   = 43;
    localparam int DIV_DEN_W   = 26;
    localparam int DIV_Q_W     = 32;
    localparam int DIV_S_W     = 6;
    localparam int MOD_STEPS   = 9;
    localparam int PHASE_STEPS = 32;
    localparam int VAL_STEPS   = FRAC_BITS + 1;
    localparam int PROD_W      = RS_W + TRIG_W - 1;

    localparam int JOB_Q_DEPTH = 2;

    typedef struct packed {
        logic [K_W-1:0]    k;
        logic [MODE_W-1:0] mode;
        logic [BAND_W-1:0] band;
    } job_t;

    typedef struct packed {
        logic [WC_W-1:0] w;
        logic [RS_W-1:0] n;
    } geom_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_S_W-1:0]   steps;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_Q_W-1:0]   quot;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

    // Arctangent of 2^-i in units of 2^-32 turns.
    function automatic logic [ATAN_W-1:0] turn_atan(input logic [IT_W-1:0] i);
        logic [ATAN_W-1:0] a;
        a = '0;
        case (i)
            5'd0:  a = ATAN_W'(536870912);
            5'd1:  a = ATAN_W'(316933406);
            5'd2:  a = ATAN_W'(167458907);
            5'd3:  a = ATAN_W'(85004756);
            5'd4:  a = ATAN_W'(42667331);
            5'd5:  a = ATAN_W'(21354465);
            5'd6:  a = ATAN_W'(10679838);
            5'd7:  a = ATAN_W'(5340245);
            5'd8:  a = ATAN_W'(2670163);
            5'd9:  a = ATAN_W'(1335087);
            5'd10: a = ATAN_W'(667544);
            5'd11: a = ATAN_W'(333772);
            5'd12: a = ATAN_W'(166886);
            5'd13: a = ATAN_W'(83443);
            5'd14: a = ATAN_W'(41722);
            5'd15: a = ATAN_W'(20861);
            5'd16: a = ATAN_W'(10430);
            5'd17: a = ATAN_W'(5215);
            5'd18: a = ATAN_W'(2608);
            5'd19: a = ATAN_W'(1304);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Vertex recipe: {angle select, level offset} for each vertex of a band.
    function automatic logic [1:0] recipe(input logic [MODE_W-1:0] mode,
                                          input logic [VIDX_W-1:0] v);
        logic [1:0] r;
        r = 2'b00;
        case (mode)
            MODE_TOP:
                case (v)
                    3'd1:    r = 2'b11;
                    3'd2:    r = 2'b01;
                    3'd4:    r = 2'b10;
                    3'd5:    r = 2'b11;
                    default: r = 2'b00;
                endcase
            MODE_BOTTOM:
                case (v)
                    3'd1:    r = 2'b01;
                    3'd2:    r = 2'b11;
                    3'd4:    r = 2'b11;
                    3'd5:    r = 2'b10;
                    default: r = 2'b00;
                endcase
            default:
                case (v)
                    3'd0:    r = 2'b01;
                    3'd1:    r = 2'b10;
                    3'd3:    r = 2'b01;
                    3'd4:    r = 2'b11;
                    3'd5:    r = 2'b10;
                    default: r = 2'b00;
                endcase
        endcase
        return r;
    endfunction

    // Signed value divided by 2^s, rounded half away from zero.
    function automatic logic [NRM_W-1:0] round_shift(input logic signed [TRIG_W-1:0] v,
                                                     input logic [IT_W-1:0] s);
        logic [TRIG_W-1:0] mag;
        logic [TRIG_W-1:0] sum;
        logic [TRIG_W-1:0] q;
        mag = v[TRIG_W-1] ? TRIG_W'(-v) : TRIG_W'(v);
        sum = mag + (TRIG_W'(1) << (s - IT_W'(1)));
        q   = sum >> s;
        return v[TRIG_W-1] ? NRM_W'(-q) : NRM_W'(q);
    endfunction

endpackage

@@ src/cmvg_if.sv @@
// Handshake interfaces for the request, vertex and configuration channels.
// Depends on cmvg_pkg for field widths.
interface cmvg_req_if;
    import cmvg_pkg::*;
    logic              valid;
    logic              ready;
    logic [K_W-1:0]    wedge_index;
    logic [MODE_W-1:0] mode;
    logic [BAND_W-1:0] band_index;
    modport source (output valid, wedge_index, mode, band_index, input ready);
    modport sink   (input valid, wedge_index, mode, band_index, output ready);
endinterface

interface cmvg_vtx_if;
    import cmvg_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [NRM_W-1:0] norm_x;
    logic [NRM_W-1:0] norm_y;
    logic [NRM_W-1:0] norm_z;
    logic             last;
    modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last,
                    output ready);
endinterface

interface cmvg_cfg_if;
    import cmvg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/cmvg_div.sv @@
// Shared bit-serial restoring divider: one quotient bit per cycle.
// Depends on cmvg_pkg for the request and response structs.
module cmvg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  cmvg_pkg::div_req_t req,
    output cmvg_pkg::div_rsp_t rsp
);
    import cmvg_pkg::*;

    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] r_reg;
    logic [DIV_NUM_W-1:0] lo_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_S_W-1:0]   cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    logic [DIV_NUM_W-1:0] start_hi;

    // The upper numerator bits start as the partial remainder; the caller
    // guarantees they are already below the divisor.
    assign start_hi = req.num >> req.steps;
    assign trial    = {r_reg, lo_reg[DIV_NUM_W-1]};
    assign ge       = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_reg  <= '0;
            r_reg    <= '0;
            lo_reg   <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Done pulses for one cycle after the final quotient bit.
            done_reg <= !req.start && busy_reg && (cnt_reg == DIV_S_W'(1));
            if (req.start)
            begin
                den_reg  <= req.den;
                r_reg    <= start_hi[DIV_DEN_W-1:0];
                lo_reg   <= req.num << (DIV_NUM_W - int'(req.steps));
                q_reg    <= '0;
                cnt_reg  <= req.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                r_reg   <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
                lo_reg  <= lo_reg << 1;
                q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
                cnt_reg <= cnt_reg - DIV_S_W'(1);
                if (cnt_reg == DIV_S_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

@@ src/cmvg_fifo.sv @@
// Short job queue between the front and back parts.
// Depends on cmvg_pkg for the job struct.
module cmvg_fifo #(
    parameter int DEPTH = cmvg_pkg::JOB_Q_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmvg_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output cmvg_pkg::job_t rdata
);
    import cmvg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ src/cmvg_front.sv @@
// Front part: configuration registers, clamping, and request classification.
// Depends on cmvg_pkg and the handshake interfaces in cmvg_if.
module cmvg_front (
    input  logic            clk,
    input  logic            rst_n,
    cmvg_cfg_if.sink        cfg,
    cmvg_req_if.sink        req,
    input  logic            q_full,
    output logic            q_push,
    output cmvg_pkg::job_t  q_data,
    output cmvg_pkg::geom_t geom
);
    import cmvg_pkg::*;

    logic [RS_W-1:0] rs_reg;
    logic [WC_W-1:0] wc_reg;
    logic            keep;

    assign cfg.ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg <= RS_RESET;
            wc_reg <= WC_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_RADIAL_STEPS: rs_reg <= cfg.data[RS_W-1:0];
                REG_WEDGE_COUNT:  wc_reg <= cfg.data[WC_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective wedge and band counts.
    always_comb
    begin
        if (wc_reg < WC_W'(MIN_WEDGES))
            geom.w = WC_W'(MIN_WEDGES);
        else if (wc_reg > WC_W'(MAX_WEDGES))
            geom.w = WC_W'(MAX_WEDGES);
        else
            geom.w = wc_reg;
        if (rs_reg == '0)
            geom.n = RS_W'(1);
        else if (rs_reg > RS_W'(MAX_BANDS))
            geom.n = RS_W'(MAX_BANDS);
        else
            geom.n = rs_reg;
    end

    // A request with an unknown surface or a band beyond the count is dropped.
    assign keep = (req.mode == MODE_TOP || req.mode == MODE_BOTTOM || req.mode == MODE_SIDE)
                  && (RS_W'(req.band_index) < geom.n);

    assign req.ready   = !q_full;
    assign q_push      = req.valid && !q_full && keep;
    assign q_data.k    = req.wedge_index;
    assign q_data.mode = req.mode;
    assign q_data.band = req.band_index;

endmodule

@@ src/cmvg_back.sv @@
// Back part: wedge angles, CORDIC sine and cosine, band values and vertex emission.
// Depends on cmvg_pkg, cmvg_if and the shared divider cmvg_div.
module cmvg_back (
    input  logic            clk,
    input  logic            rst_n,
    input  cmvg_pkg::geom_t geom,
    input  logic            q_valid,
    input  cmvg_pkg::job_t  q_data,
    output logic            q_pop,
    cmvg_vtx_if.source      vtx
);
    import cmvg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_MOD_WAIT, ST_PHASE, ST_PHASE_WAIT, ST_ROTATE,
        ST_ROT_END, ST_MUL, ST_DIV, ST_DIV_WAIT, ST_EMIT
    } state_t;

    localparam logic signed [XY_W-1:0] Q30_POS = XY_W'(1073741824);
    localparam logic signed [XY_W-1:0] Q30_NEG = -XY_W'(1073741824);

    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
        if (v > Q30_POS)
            return Q30_ONE;
        else if (v < Q30_NEG)
            return -Q30_ONE;
        else
            return $signed(v[TRIG_W-1:0]);
    endfunction

    state_t                     state_reg;
    job_t                       job_reg;
    logic [K_W-1:0]             a_reg;
    logic [K_W-1:0]             b_reg;
    logic                       sel_reg;
    logic signed [XY_W-1:0]     x_reg;
    logic signed [XY_W-1:0]     y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [IT_W-1:0]            it_reg;
    logic                       flip_reg;
    logic signed [TRIG_W-1:0]   cos0_reg;
    logic signed [TRIG_W-1:0]   sin0_reg;
    logic signed [TRIG_W-1:0]   cos1_reg;
    logic signed [TRIG_W-1:0]   sin1_reg;
    logic [2:0]                 d_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic [POS_W-1:0]           valx_reg [4];
    logic [POS_W-1:0]           valz_reg [4];
    logic [POS_W-1:0]           py_reg [2];
    logic [VIDX_W-1:0]          v_reg;
    logic                       out_valid_reg;
    logic [POS_W-1:0]           px_reg;
    logic [POS_W-1:0]           py_out_reg;
    logic [POS_W-1:0]           pz_reg;
    logic [NRM_W-1:0]           nx_reg;
    logic [NRM_W-1:0]           ny_reg;
    logic [NRM_W-1:0]           nz_reg;
    logic                       last_reg;

    div_req_t                   dreq;
    div_rsp_t                   drsp;

    logic                       is_side;
    logic signed [TRIG_W-1:0]   mul_v;
    logic [TRIG_W-1:0]          mul_mag;
    logic [RS_W-1:0]            cap_lev;
    logic [RS_W-1:0]            side_lev;
    logic signed [RS_W+1:0]     side_diff;
    logic [RS_W:0]              side_mag;
    logic [K_W-1:0]             phase_j;
    logic [K_W:0]               a_inc;
    logic [DIV_Q_W-1:0]         ph_fold;
    logic                       fold;
    logic signed [XY_W-1:0]     dx;
    logic signed [XY_W-1:0]     dy;
    logic signed [Z_W-1:0]      atan_ext;
    logic signed [XY_W-1:0]     x_fin;
    logic signed [XY_W-1:0]     y_fin;
    logic [POS_W-1:0]           q_val;
    logic [POS_W-1:0]           s_val;
    logic                       last_div;
    logic [1:0]                 rc;
    logic signed [TRIG_W-1:0]   e_cos;
    logic signed [TRIG_W-1:0]   e_sin;
    logic [POS_W-1:0]           e_px;
    logic [POS_W-1:0]           e_py;
    logic [POS_W-1:0]           e_pz;
    logic [NRM_W-1:0]           e_nx;
    logic [NRM_W-1:0]           e_ny;
    logic [NRM_W-1:0]           e_nz;
    logic                       out_free;

    cmvg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign is_side = job_reg.mode == MODE_SIDE;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;

    // Operands of the value currently being worked out.
    always_comb
    begin
        if (d_reg[2])
            mul_v = d_reg[0] ? sin1_reg : cos1_reg;
        else
            mul_v = d_reg[0] ? sin0_reg : cos0_reg;
        mul_mag   = mul_v[TRIG_W-1] ? TRIG_W'(-mul_v) : TRIG_W'(mul_v);
        cap_lev   = RS_W'(job_reg.band) + RS_W'(d_reg[1]);
        side_lev  = RS_W'(job_reg.band) + RS_W'(d_reg[0]);
        side_diff = $signed({1'b0, side_lev, 1'b0}) - $signed({2'b00, geom.n});
        side_mag  = side_diff[RS_W+1] ? (RS_W+1)'(-side_diff) : side_diff[RS_W:0];
        phase_j   = sel_reg ? b_reg : a_reg;
        a_inc     = {1'b0, drsp.rem[K_W-1:0]} + (K_W+1)'(1);
        last_div  = is_side ? (d_reg == 3'd1) : (d_reg == 3'd7);
    end

    // Divider requests.
    always_comb
    begin
        dreq = '0;
        case (state_reg)
            ST_MOD:
            begin
                dreq.start = 1'b1;
                dreq.num   = DIV_NUM_W'(job_reg.k);
                dreq.den   = DIV_DEN_W'(geom.w);
                dreq.steps = DIV_S_W'(MOD_STEPS);
            end
            ST_PHASE:
            begin
                dreq.start = 1'b1;
                dreq.num   = (DIV_NUM_W'(phase_j) << 32) + DIV_NUM_W'(geom.w >> 1);
                dreq.den   = DIV_DEN_W'(geom.w);
                dreq.steps = DIV_S_W'(PHASE_STEPS);
            end
            ST_DIV:
            begin
                dreq.start = 1'b1;
                dreq.steps = DIV_S_W'(VAL_STEPS);
                if (is_side)
                begin
                    dreq.num = DIV_NUM_W'(prod_reg) + DIV_NUM_W'(geom.n);
                    dreq.den = DIV_DEN_W'(geom.n) << 1;
                end
                else
                begin
                    dreq.num = DIV_NUM_W'(prod_reg) + (DIV_NUM_W'(geom.n) << NRM_SHIFT);
                    dreq.den = DIV_DEN_W'(geom.n) << POS_SHIFT;
                end
            end
            default: ;
        endcase
    end

    // Phase fold, CORDIC micro-rotation and final sign and clamp.
    always_comb
    begin
        fold     = (drsp.quot - DIV_Q_W'(32'h4000_0000)) < DIV_Q_W'(32'h8000_0000);
        ph_fold  = fold ? drsp.quot - DIV_Q_W'(32'h8000_0000) : drsp.quot;
        dx       = y_reg >>> it_reg;
        dy       = x_reg >>> it_reg;
        atan_ext = $signed(Z_W'(turn_atan(it_reg)));
        x_fin    = flip_reg ? -x_reg : x_reg;
        y_fin    = flip_reg ? -y_reg : y_reg;
        q_val    = drsp.quot[POS_W-1:0];
        s_val    = neg_reg ? POS_W'(-q_val) : q_val;
    end

    // Vertex assembly.
    always_comb
    begin
        rc    = recipe(job_reg.mode, v_reg);
        e_cos = rc[1] ? cos1_reg : cos0_reg;
        e_sin = rc[1] ? sin1_reg : sin0_reg;
        if (is_side)
        begin
            e_px = POS_W'(round_shift(e_cos, IT_W'(POS_SHIFT)));
            e_pz = POS_W'(round_shift(e_sin, IT_W'(POS_SHIFT)));
            e_py = py_reg[rc[0]];
            e_nx = round_shift(e_cos, IT_W'(NRM_SHIFT));
            e_nz = round_shift(e_sin, IT_W'(NRM_SHIFT));
            e_ny = '0;
        end
        else
        begin
            e_px = valx_reg[rc];
            e_pz = valz_reg[rc];
            e_py = (job_reg.mode == MODE_TOP) ? CAP_Y : POS_W'(-CAP_Y);
            e_nx = '0;
            e_nz = '0;
            e_ny = (job_reg.mode == MODE_TOP) ? NRM_ONE : NRM_W'(-NRM_ONE);
        end
    end

    assign out_free = !out_valid_reg || vtx.ready;

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            sel_reg       <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            it_reg        <= '0;
            flip_reg      <= 1'b0;
            cos0_reg      <= '0;
            sin0_reg      <= '0;
            cos1_reg      <= '0;
            sin1_reg      <= '0;
            d_reg         <= '0;
            prod_reg      <= '0;
            neg_reg       <= 1'b0;
            valx_reg      <= '{default: '0};
            valz_reg      <= '{default: '0};
            py_reg        <= '{default: '0};
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            px_reg        <= '0;
            py_out_reg    <= '0;
            pz_reg        <= '0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            nz_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Outside emission a taken beat empties the output register.
            if (vtx.ready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg   <= q_data;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD:
                begin
                    state_reg <= ST_MOD_WAIT;
                end
                ST_MOD_WAIT:
                begin
                    if (drsp.done)
                    begin
                        a_reg     <= drsp.rem[K_W-1:0];
                        b_reg     <= (a_inc == (K_W+1)'(geom.w)) ? '0 : a_inc[K_W-1:0];
                        sel_reg   <= 1'b0;
                        state_reg <= ST_PHASE;
                    end
                end
                ST_PHASE:
                begin
                    state_reg <= ST_PHASE_WAIT;
                end
                ST_PHASE_WAIT:
                begin
                    if (drsp.done)
                    begin
                        flip_reg  <= fold;
                        z_reg     <= $signed({{(Z_W-DIV_Q_W){ph_fold[DIV_Q_W-1]}}, ph_fold});
                        x_reg     <= CORDIC_X0;
                        y_reg     <= '0;
                        it_reg    <= '0;
                        state_reg <= ST_ROTATE;
                    end
                end
                ST_ROTATE:
                begin
                    if (z_reg[Z_W-1])
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_ext;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_ext;
                    end
                    it_reg <= it_reg + IT_W'(1);
                    if (it_reg == IT_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_ROT_END;
                    end
                end
                ST_ROT_END:
                begin
                    if (sel_reg)
                    begin
                        cos1_reg  <= clamp_unit(x_fin);
                        sin1_reg  <= clamp_unit(y_fin);
                        d_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        cos0_reg  <= clamp_unit(x_fin);
                        sin0_reg  <= clamp_unit(y_fin);
                        sel_reg   <= 1'b1;
                        state_reg <= ST_PHASE;
                    end
                end
                ST_MUL:
                begin
                    if (is_side)
                    begin
                        prod_reg <= PROD_W'(side_mag) << FRAC_BITS;
                        neg_reg  <= side_diff[RS_W+1];
                    end
                    else
                    begin
                        prod_reg <= PROD_W'(cap_lev) * PROD_W'(mul_mag[TRIG_W-2:0]);
                        neg_reg  <= mul_v[TRIG_W-1];
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (drsp.done)
                    begin
                        if (is_side)
                            py_reg[d_reg[0]] <= s_val;
                        else if (d_reg[0])
                            valz_reg[d_reg[2:1]] <= s_val;
                        else
                            valx_reg[d_reg[2:1]] <= s_val;
                        d_reg <= d_reg + 3'd1;
                        if (last_div)
                        begin
                            v_reg     <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        px_reg        <= e_px;
                        py_out_reg    <= e_py;
                        pz_reg        <= e_pz;
                        nx_reg        <= e_nx;
                        ny_reg        <= e_ny;
                        nz_reg        <= e_nz;
                        last_reg      <= v_reg == VIDX_W'(VERTS - 1);
                        v_reg         <= v_reg + VIDX_W'(1);
                        if (v_reg == VIDX_W'(VERTS - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign vtx.valid  = out_valid_reg;
    assign vtx.pos_x  = px_reg;
    assign vtx.pos_y  = py_out_reg;
    assign vtx.pos_z  = pz_reg;
    assign vtx.norm_x = nx_reg;
    assign vtx.norm_y = ny_reg;
    assign vtx.norm_z = nz_reg;
    assign vtx.last   = last_reg;

endmodule

@@ src/cylinder_mesh_vertex_generator.sv @@
// Top level of the cylinder mesh vertex generator: front, job queue and back.
// Depends on cmvg_pkg, cmvg_if, cmvg_front, cmvg_fifo and cmvg_back.
//
//  Channel | Direction | Beat carries
//  --------+-----------+------------------------------------------------------
//  cfg     | in        | index, data: one register write
//  req     | in        | wedge_index, mode, band_index: one band request
//  vtx     | out       | pos_x/y/z, norm_x/y/z, last: one vertex, six per band
//
// A band's work is set by the shared bit-serial divider (one quotient bit a
// cycle, eleven divisions for a cap and five for a side) and the 20-step
// CORDIC run twice. The six vertices then leave one per cycle while vtx.ready
// is high.
// rst_n clears the registers to one band and three wedges; no clearing pass.
// The front keeps taking requests into a two-entry queue while the back works,
// and a stalled vertex beat holds in the output register.
module cylinder_mesh_vertex_generator #(
    parameter int JOB_Q_DEPTH = cmvg_pkg::JOB_Q_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    cmvg_cfg_if.sink   cfg,
    cmvg_req_if.sink   req,
    cmvg_vtx_if.source vtx
);
    import cmvg_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    job_t  q_wdata;
    job_t  q_rdata;
    geom_t geom;

    cmvg_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata),
        .geom   (geom)
    );

    cmvg_fifo #(
        .DEPTH (JOB_Q_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    cmvg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .vtx     (vtx)
    );

endmodule

@@ src/cmvg_checker.sv @@
// Port-level checks of the vertex stream, bound to the top level.
// Depends on cmvg_pkg for field widths and cap constants.
module cmvg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [cmvg_pkg::POS_W-1:0] pos_y,
    input logic [cmvg_pkg::NRM_W-1:0] norm_x,
    input logic [cmvg_pkg::NRM_W-1:0] norm_y,
    input logic [cmvg_pkg::NRM_W-1:0] norm_z,
    input logic                       last
);
    import cmvg_pkg::*;

    logic [VIDX_W-1:0] beat_cnt_reg;
    logic              beat;

    assign beat = out_valid && out_ready;

    // Position of the current beat within its band.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_cnt_reg <= '0;
        else if (beat)
            beat_cnt_reg <= last ? '0 : beat_cnt_reg + VIDX_W'(1);
    end

    // A stalled beat keeps its valid, its last flag and its y position.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(last) && $stable(pos_y))
        else $error("vertex beat changed while stalled");

    // Every band closes on its sixth beat.
    a_last_sixth: assert property (@(posedge clk) disable iff (!rst_n)
        beat && last |-> beat_cnt_reg == VIDX_W'(VERTS - 1))
        else $error("last not on the sixth vertex");

    a_no_seventh: assert property (@(posedge clk) disable iff (!rst_n)
        beat && !last |-> beat_cnt_reg != VIDX_W'(VERTS - 1))
        else $error("band runs past six vertices");

    // Top cap vertices face straight up at the cap height.
    a_cap_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && norm_y == NRM_ONE |-> norm_x == '0 && norm_z == '0 && pos_y == CAP_Y)
        else $error("top cap vertex malformed");

endmodule

bind cylinder_mesh_vertex_generator cmvg_checker u_cmvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (vtx.valid),
    .out_ready (vtx.ready),
    .pos_y     (vtx.pos_y),
    .norm_x    (vtx.norm_x),
    .norm_y    (vtx.norm_y),
    .norm_z    (vtx.norm_z),
    .last      (vtx.last)
);
